// File: rtl/cdad_pkg.sv
// shared types, codes and tables for the calendar date add-days block
// no dependencies; used by every module in rtl/
package cdad_pkg;

    // field widths of the item and result beats
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int STATUS_W = 2;

    // parameter defaults
    localparam int MAX_YEAR_DEF  = 9999;
    localparam int ADD_WIDTH_DEF = 16;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // year mod 25 tells centuries apart: 100 = 4*25, 400 = 16*25
    localparam int CENTURY_DIV = 25;
    localparam int YMOD_W      = 5;

    // reciprocal of 25 for the year remainder, exact for years below 2^16
    localparam int RECIP_25    = 83887;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 17;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // class of an item as found by the front
    typedef enum logic [1:0] {
        KIND_NORMAL    = 2'd0,
        KIND_BAD_MONTH = 2'd1,
        KIND_OVER_MAX  = 2'd2
    } kind_t;

    // internal year width: wide enough for the saturation limit
    function automatic int year_bits(input int max_year);
        int b;
        begin
            b = $clog2(max_year + 1);
            return (b > YEAR_W) ? b : YEAR_W;
        end
    endfunction

    // width of one queue entry
    function automatic int entry_bits(input int max_year, input int add_width);
        begin
            return $bits(kind_t) + YMOD_W + add_width + DAY_W + MONTH_W
                + year_bits(max_year);
        end
    endfunction

    // month length, february lengthened in leap years
    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] m,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd2:                 len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                default:              len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: rtl/cdad_front.sv
// front part: takes the item beat, classifies it and works out year mod 25
// depends on cdad_pkg; feeds cdad_queue
module cdad_front #(
    parameter int MAX_YEAR  = cdad_pkg::MAX_YEAR_DEF,
    parameter int ADD_WIDTH = cdad_pkg::ADD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cdad_pkg::YEAR_W-1:0]   start_year,
    input  logic [cdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [cdad_pkg::DAY_W-1:0]    start_day,
    input  logic [ADD_WIDTH-1:0]          days_to_add,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [cdad_pkg::entry_bits(MAX_YEAR, ADD_WIDTH)-1:0] q_wdata
);

    localparam int YW = cdad_pkg::year_bits(MAX_YEAR);
    localparam int PW = YW + cdad_pkg::RECIP_W;
    localparam int QW = PW - cdad_pkg::RECIP_SHIFT;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_MOD  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t                         state_reg, state_next;
    logic [YW-1:0]                   year_reg;
    logic [cdad_pkg::MONTH_W-1:0]    month_reg;
    logic [cdad_pkg::DAY_W-1:0]      day_reg;
    logic [ADD_WIDTH-1:0]            count_reg;
    logic [QW-1:0]                   quo_reg, quo_next;
    logic [cdad_pkg::YMOD_W-1:0]     rem_reg, rem_next;
    cdad_pkg::kind_t                 kind_reg, kind_in;
    logic [YW-1:0]                   year_in;
    logic                            accept;

    assign busy   = (state_reg != F_IDLE);
    assign accept = start && (state_reg == F_IDLE);
    assign year_in = YW'(start_year);

    // classify the incoming beat
    always_comb
    begin
        if (start_month < cdad_pkg::MONTH_JAN || start_month > cdad_pkg::MONTH_DEC)
        begin
            kind_in = cdad_pkg::KIND_BAD_MONTH;
        end
        else if (year_in > YW'(MAX_YEAR))
        begin
            kind_in = cdad_pkg::KIND_OVER_MAX;
        end
        else
        begin
            kind_in = cdad_pkg::KIND_NORMAL;
        end
    end

    // year mod 25: quotient by reciprocal multiply, then multiply back and subtract
    assign quo_next = QW'((PW'(year_reg) * PW'(cdad_pkg::RECIP_25)) >> cdad_pkg::RECIP_SHIFT);
    assign rem_next = cdad_pkg::YMOD_W'(year_reg
        - YW'(quo_reg) * YW'(cdad_pkg::CENTURY_DIV));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_MOD;
            end
            F_MOD:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item payload and remainder unit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            year_reg  <= year_in;
            month_reg <= start_month;
            day_reg   <= (start_day == '0) ? cdad_pkg::DAY_W'(1) : start_day;
            count_reg <= days_to_add;
            kind_reg  <= kind_in;
        end
        else if (state_reg == F_MUL)
        begin
            quo_reg <= quo_next;
        end
        else if (state_reg == F_MOD)
        begin
            rem_reg <= rem_next;
        end
    end

    assign q_wdata = {kind_reg, rem_reg, count_reg, day_reg, month_reg, year_reg};

endmodule

// File: rtl/cdad_queue.sv
// short register queue between the front and the back
// depends on cdad_pkg for its depth
module cdad_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (cdad_pkg::Q_DEPTH > 1) ? $clog2(cdad_pkg::Q_DEPTH) : 1;
    localparam int NW = $clog2(cdad_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [cdad_pkg::Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    fill_reg;

    assign full  = (fill_reg == NW'(cdad_pkg::Q_DEPTH));
    assign empty = (fill_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // pointer that wraps at the depth
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        begin
            return (p == PW'(cdad_pkg::Q_DEPTH - 1)) ? '0 : p + PW'(1);
        end
    endfunction

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/cdad_back.sv
// back part: walks the date forward one month per cycle and drives the result
// depends on cdad_pkg; fed by cdad_queue
module cdad_back #(
    parameter int MAX_YEAR  = cdad_pkg::MAX_YEAR_DEF,
    parameter int ADD_WIDTH = cdad_pkg::ADD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [cdad_pkg::entry_bits(MAX_YEAR, ADD_WIDTH)-1:0] q_rdata,
    output logic                          q_pop,
    output logic                          done,
    output logic [cdad_pkg::YEAR_W-1:0]   result_year,
    output logic [cdad_pkg::MONTH_W-1:0]  result_month,
    output logic [cdad_pkg::DAY_W-1:0]    result_day,
    output logic [cdad_pkg::STATUS_W-1:0] status
);

    localparam int YW  = cdad_pkg::year_bits(MAX_YEAR);
    localparam int DW  = ADD_WIDTH + 1;
    localparam int YM_LO = YW + cdad_pkg::MONTH_W + cdad_pkg::DAY_W + ADD_WIDTH;
    localparam int K_LO  = YM_LO + cdad_pkg::YMOD_W;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } bstate_t;

    bstate_t                       state_reg;
    logic [YW-1:0]                 year_reg;
    logic [cdad_pkg::MONTH_W-1:0]  month_reg;
    logic [DW-1:0]                 day_reg;
    logic [cdad_pkg::YMOD_W-1:0]   ymod_reg;
    logic                          done_reg;
    logic [cdad_pkg::YEAR_W-1:0]   ryear_reg;
    logic [cdad_pkg::MONTH_W-1:0]  rmonth_reg;
    logic [cdad_pkg::DAY_W-1:0]    rday_reg;
    logic [cdad_pkg::STATUS_W-1:0] rstatus_reg;

    // queue entry fields
    logic [YW-1:0]                 e_year;
    logic [cdad_pkg::MONTH_W-1:0]  e_month;
    logic [cdad_pkg::DAY_W-1:0]    e_day;
    logic [ADD_WIDTH-1:0]          e_count;
    logic [cdad_pkg::YMOD_W-1:0]   e_ymod;
    cdad_pkg::kind_t               e_kind;

    logic                          leap;
    logic [cdad_pkg::DAY_W-1:0]    len;
    logic                          past_end;
    logic                          year_wrap;
    logic                          at_max;

    assign e_year  = q_rdata[YW-1:0];
    assign e_month = q_rdata[YW +: cdad_pkg::MONTH_W];
    assign e_day   = q_rdata[YW + cdad_pkg::MONTH_W +: cdad_pkg::DAY_W];
    assign e_count = q_rdata[YW + cdad_pkg::MONTH_W + cdad_pkg::DAY_W +: ADD_WIDTH];
    assign e_ymod  = q_rdata[YM_LO +: cdad_pkg::YMOD_W];
    assign e_kind  = cdad_pkg::kind_t'(q_rdata[K_LO +: $bits(cdad_pkg::kind_t)]);

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    // gregorian leap test: by 4, not by 100 unless by 400
    assign leap = (year_reg[1:0] == 2'b00)
        && ((ymod_reg != '0) || (year_reg[3:0] == 4'b0000));
    assign len       = cdad_pkg::month_days(month_reg, leap);
    assign past_end  = (day_reg > DW'(len));
    assign year_wrap = (month_reg == cdad_pkg::MONTH_DEC);
    assign at_max    = (year_reg >= YW'(MAX_YEAR));

    // control and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (e_kind == cdad_pkg::KIND_NORMAL)
                        begin
                            state_reg <= B_RUN;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                B_RUN:
                begin
                    if (!past_end || (year_wrap && at_max))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // month walk and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            if (q_pop)
            begin
                year_reg  <= e_year;
                month_reg <= e_month;
                day_reg   <= DW'(e_day) + DW'(e_count);
                ymod_reg  <= e_ymod;
                if (e_kind == cdad_pkg::KIND_BAD_MONTH)
                begin
                    ryear_reg   <= '0;
                    rmonth_reg  <= '0;
                    rday_reg    <= '0;
                    rstatus_reg <= cdad_pkg::ST_BAD_MONTH;
                end
                else
                begin
                    ryear_reg   <= cdad_pkg::YEAR_W'(MAX_YEAR);
                    rmonth_reg  <= cdad_pkg::MONTH_DEC;
                    rday_reg    <= cdad_pkg::DAY_LAST;
                    rstatus_reg <= cdad_pkg::ST_OVERFLOW;
                end
            end
        end
        else if (!past_end)
        begin
            // date is normalized
            ryear_reg   <= year_reg[cdad_pkg::YEAR_W-1:0];
            rmonth_reg  <= month_reg;
            rday_reg    <= day_reg[cdad_pkg::DAY_W-1:0];
            rstatus_reg <= cdad_pkg::ST_OK;
        end
        else if (year_wrap && at_max)
        begin
            // ran past the last year: saturate
            ryear_reg   <= cdad_pkg::YEAR_W'(MAX_YEAR);
            rmonth_reg  <= cdad_pkg::MONTH_DEC;
            rday_reg    <= cdad_pkg::DAY_LAST;
            rstatus_reg <= cdad_pkg::ST_OVERFLOW;
        end
        else
        begin
            // consume one month
            day_reg <= day_reg - DW'(len);
            if (year_wrap)
            begin
                month_reg <= cdad_pkg::MONTH_JAN;
                year_reg  <= year_reg + YW'(1);
                ymod_reg  <= (ymod_reg == cdad_pkg::YMOD_W'(cdad_pkg::CENTURY_DIV - 1))
                    ? '0 : ymod_reg + cdad_pkg::YMOD_W'(1);
            end
            else
            begin
                month_reg <= month_reg + cdad_pkg::MONTH_W'(1);
            end
        end
    end

    assign done         = done_reg;
    assign result_year  = ryear_reg;
    assign result_month = rmonth_reg;
    assign result_day   = rday_reg;
    assign status       = rstatus_reg;

endmodule

// File: rtl/calendar_date_add_days.sv
// top level of the calendar date add-days block
// depends on cdad_pkg, cdad_front, cdad_queue and cdad_back
//
// An item is taken when start is high and busy is low. The front holds busy
// through its multiply, remainder and push states while a reciprocal multiply
// works out the year modulo 25 for the leap test, and stays in the push state
// while the queue is full. The back then walks the date one month per cycle
// until the day fits its month or the last year is passed; an illegal month or
// a start year past the limit needs no walk and its result is registered as
// the back pops it from the queue. A two-beat queue lets the front take the
// next item while the back is still walking. Each result appears for exactly
// one cycle with done high and must be captured then; results leave in the
// order the items came in.
module calendar_date_add_days #(
    parameter int MAX_YEAR  = cdad_pkg::MAX_YEAR_DEF,
    parameter int ADD_WIDTH = cdad_pkg::ADD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cdad_pkg::YEAR_W-1:0]   start_year,
    input  logic [cdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [cdad_pkg::DAY_W-1:0]    start_day,
    input  logic [ADD_WIDTH-1:0]          days_to_add,
    output logic                          done,
    output logic [cdad_pkg::YEAR_W-1:0]   result_year,
    output logic [cdad_pkg::MONTH_W-1:0]  result_month,
    output logic [cdad_pkg::DAY_W-1:0]    result_day,
    output logic [cdad_pkg::STATUS_W-1:0] status
);

    localparam int EW = cdad_pkg::entry_bits(MAX_YEAR, ADD_WIDTH);

    logic          q_push, q_pop, q_full, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;

    // accept and classify
    cdad_front #(
        .MAX_YEAR  (MAX_YEAR),
        .ADD_WIDTH (ADD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .start_year  (start_year),
        .start_month (start_month),
        .start_day   (start_day),
        .days_to_add (days_to_add),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    // decoupling queue
    cdad_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // month walk
    cdad_back #(
        .MAX_YEAR  (MAX_YEAR),
        .ADD_WIDTH (ADD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .done         (done),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .status       (status)
    );

endmodule
